// ===== rtl/sest_pkg.sv =====
// Shared types, constants and codes for the syscall event stats table.
`timescale 1ns / 1ps
package sest_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS    = 10;
  localparam int TIME_BITS   = 48;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_STOP  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [47:0] CALL_MAX = {48{1'b1}};
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Request as it arrives on the input channel
  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  call_num;
    logic [47:0] timestamp;
    logic [9:0]  slot;
  } req_t;

  // Result as it leaves on the output channel
  typedef struct packed {
    logic        valid_res;
    logic [9:0]  entry_key;
    logic [47:0] entry_calls;
    logic [47:0] total_ticks;
    logic [9:0]  entry_rank;
    logic [10:0] entries_used;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_EXIT,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  // Classified work item passed from front to back
  typedef struct packed {
    cmd_kind_t            kind;
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] elapsed;
    logic [9:0]           slot;
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_UPDATE,
    ST_SLOT,
    ST_RANK,
    ST_REPLY
  } back_state_t;

endpackage

// ===== rtl/sest_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sest_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sest_front.sv =====
// Front end: accepts requests, tracks entry/exit phase and classifies work.
`timescale 1ns / 1ps
module sest_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sest_pkg::req_t req,
  input  logic          q_full,
  output logic          q_push,
  output sest_pkg::cmd_t q_cmd
);
  import sest_pkg::*;

  logic                 expect_entry;
  logic [KEY_BITS-1:0]  pending_key;
  logic [TIME_BITS-1:0] entry_stamp;
  logic                 accept;
  q_ctl_t               ctl;

  assign req_ready = ~q_full;
  assign accept    = req_valid & req_ready;

  // Decide what goes to the back end
  always_comb begin
    ctl.full      = q_full;
    ctl.push      = 1'b0;
    q_cmd.kind    = CMD_READ;
    q_cmd.key     = pending_key;
    q_cmd.elapsed = req.timestamp[TIME_BITS-1:0] - entry_stamp;
    q_cmd.slot    = req.slot;
    if (accept) begin
      unique case (req.operation)
        OP_STOP: begin
          if (!expect_entry) begin
            ctl.push   = 1'b1;
            q_cmd.kind = CMD_EXIT;
          end
        end
        OP_READ: begin
          ctl.push   = 1'b1;
          q_cmd.kind = CMD_READ;
        end
        OP_CLEAR: begin
          ctl.push   = 1'b1;
          q_cmd.kind = CMD_CLEAR;
        end
        default: ctl.push = 1'b0;
      endcase
    end
  end

  assign q_push = ctl.push & ~ctl.full;

  // Latch the entry stop and flip the phase
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_entry <= 1'b1;
      pending_key  <= '0;
      entry_stamp  <= '0;
    end else if (accept && req.operation == OP_STOP) begin
      if (expect_entry) begin
        pending_key <= req.call_num[KEY_BITS-1:0];
        entry_stamp <= req.timestamp[TIME_BITS-1:0];
      end
      expect_entry <= ~expect_entry;
    end
  end

endmodule

// ===== rtl/sest_queue.sv =====
// Short command queue between the front and the back end.
`timescale 1ns / 1ps
module sest_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sest_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output sest_pkg::cmd_t pop_cmd
);
  import sest_pkg::*;

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] fill;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (fill == QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sest_back.sv =====
// Back end: scans the table for exits and reads, owns the RAMs and result register.
`timescale 1ns / 1ps
module sest_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  sest_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sest_pkg::rsp_t rsp
);
  import sest_pkg::*;

  back_state_t          state, state_next;
  cmd_t                 cmd, cmd_next;
  logic [CNT_BITS-1:0]  used, used_next;
  logic [CNT_BITS-1:0]  idx, idx_next;
  logic [IDX_BITS-1:0]  idx_d, idx_d_next;
  logic                 rd_pend, rd_pend_next;
  logic                 res_valid, res_valid_next;
  logic [KEY_BITS-1:0]  res_key, res_key_next;
  logic [47:0]          res_calls, res_calls_next;
  logic [TIME_BITS-1:0] res_time, res_time_next;
  logic [9:0]           res_rank, res_rank_next;
  logic                 rsp_valid_next;
  rsp_t                 rsp_next;

  logic                 ram_we;
  logic [IDX_BITS-1:0]  waddr;
  logic [IDX_BITS-1:0]  raddr;
  logic [KEY_BITS-1:0]  key_wdata, key_rdata;
  logic [47:0]          calls_wdata, calls_rdata;
  logic [TIME_BITS-1:0] time_wdata, time_rdata;
  logic [TIME_BITS:0]   time_sum;
  logic                 key_match;
  logic                 more;

  sest_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(key_wdata),
    .raddr(raddr), .rdata(key_rdata)
  );

  sest_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_calls_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(calls_wdata),
    .raddr(raddr), .rdata(calls_rdata)
  );

  sest_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_DEPTH)) u_time_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(time_wdata),
    .raddr(raddr), .rdata(time_rdata)
  );

  assign key_match = rd_pend && (key_rdata == cmd.key);
  assign more      = (idx < used);
  assign time_sum  = {1'b0, time_rdata} + {1'b0, cmd.elapsed};

  // Next state, RAM control and result assembly
  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    used_next      = used;
    idx_next       = idx;
    idx_d_next     = idx_d;
    rd_pend_next   = rd_pend;
    res_valid_next = res_valid;
    res_key_next   = res_key;
    res_calls_next = res_calls;
    res_time_next  = res_time;
    res_rank_next  = res_rank;
    rsp_valid_next = rsp_valid & ~rsp_ready;
    rsp_next       = rsp;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    waddr          = used[IDX_BITS-1:0];
    raddr          = idx[IDX_BITS-1:0];
    key_wdata      = cmd.key;
    calls_wdata    = 48'd1;
    time_wdata     = cmd.elapsed;

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_next = q_cmd;
          unique case (q_cmd.kind)
            CMD_EXIT: begin
              idx_next     = '0;
              rd_pend_next = 1'b0;
              state_next   = ST_FIND;
            end
            CMD_READ: begin
              if (CNT_BITS'(q_cmd.slot) < used) begin
                raddr      = q_cmd.slot[IDX_BITS-1:0];
                state_next = ST_SLOT;
              end else begin
                res_valid_next = 1'b0;
                res_key_next   = '0;
                res_calls_next = '0;
                res_time_next  = '0;
                res_rank_next  = '0;
                state_next     = ST_REPLY;
              end
            end
            CMD_CLEAR: used_next = '0;
            default: state_next = ST_IDLE;
          endcase
        end
      end

      // Walk keys in slot order; one compare per cycle behind the read
      ST_FIND: begin
        if (key_match) begin
          raddr      = idx_d;
          state_next = ST_UPDATE;
        end else if (more) begin
          raddr        = idx[IDX_BITS-1:0];
          idx_d_next   = idx[IDX_BITS-1:0];
          idx_next     = idx + 1'b1;
          rd_pend_next = 1'b1;
        end else begin
          // Key absent: append a fresh entry unless the table is full
          if (used != CNT_BITS'(TABLE_DEPTH)) begin
            ram_we    = 1'b1;
            used_next = used + 1'b1;
          end
          state_next = ST_IDLE;
        end
      end

      // Add one call and the elapsed ticks, both saturating
      ST_UPDATE: begin
        ram_we      = 1'b1;
        waddr       = idx_d;
        calls_wdata = (calls_rdata == CALL_MAX) ? CALL_MAX : calls_rdata + 48'd1;
        time_wdata  = time_sum[TIME_BITS] ? TIME_MAX : time_sum[TIME_BITS-1:0];
        state_next  = ST_IDLE;
      end

      ST_SLOT: begin
        res_valid_next = 1'b1;
        res_key_next   = key_rdata;
        res_calls_next = calls_rdata;
        res_time_next  = time_rdata;
        res_rank_next  = '0;
        idx_next       = '0;
        rd_pend_next   = 1'b0;
        state_next     = ST_RANK;
      end

      // Count entries ahead of the read slot in count-descending order
      ST_RANK: begin
        if (rd_pend) begin
          if (calls_rdata > res_calls ||
              (calls_rdata == res_calls && idx_d < cmd.slot[IDX_BITS-1:0])) begin
            res_rank_next = res_rank + 1'b1;
          end
        end
        rd_pend_next = more;
        if (more) begin
          raddr      = idx[IDX_BITS-1:0];
          idx_d_next = idx[IDX_BITS-1:0];
          idx_next   = idx + 1'b1;
        end else if (!rd_pend) begin
          state_next = ST_REPLY;
        end
      end

      // Load the output register once it is free
      ST_REPLY: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next        = 1'b1;
          rsp_next.valid_res    = res_valid;
          rsp_next.entry_key    = res_key;
          rsp_next.entry_calls  = res_calls;
          rsp_next.total_ticks  = res_time;
          rsp_next.entry_rank   = res_rank;
          rsp_next.entries_used = used;
          state_next            = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      rsp_valid <= rsp_valid_next;
      rd_pend   <= rd_pend_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    idx       <= idx_next;
    idx_d     <= idx_d_next;
    res_valid <= res_valid_next;
    res_key   <= res_key_next;
    res_calls <= res_calls_next;
    res_time  <= res_time_next;
    res_rank  <= res_rank_next;
    rsp       <= rsp_next;
  end

endmodule

// ===== rtl/syscall_event_stats_table_unit.sv =====
// Top level of the syscall event stats table: front, queue and back end.
// An entry stop is absorbed by the front; past the queue an exit scans keys in slot order,
// updating the entry on a hit or appending one on a miss; an occupied-slot read ranks the
// slot by a one-entry-per-cycle scan of the used entries; an empty-slot read skips it.
// Throughput: one request per cycle while the 2-deep queue has room; else set by the scan.
// Reset clears phase, fill count, queue and result valid; table RAM is not cleared.
`timescale 1ns / 1ps
module syscall_event_stats_table_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sest_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sest_pkg::rsp_t rsp
);
  import sest_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  sest_front u_front (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .q_full(q_full), .q_push(q_push), .q_cmd(push_cmd)
  );

  sest_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_cmd(push_cmd), .full(q_full),
    .pop(q_pop), .pop_valid(q_valid), .pop_cmd(pop_cmd)
  );

  sest_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_cmd(pop_cmd), .q_pop(q_pop),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

endmodule

// ===== bench/stats_table_checker.sv =====
// Checker that predicts stats table read results and compares them with the block's output.
`timescale 1ns / 1ps
module stats_table_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  sest_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  sest_pkg::rsp_t rsp,
  input  logic           drain_done,
  output int             errors,
  output int             pending
);
  import sest_pkg::*;

  // Predicted table state
  logic                 awaiting_entry;
  logic [KEY_BITS-1:0]  latched_key;
  logic [TIME_BITS-1:0] latched_stamp;
  int                   slots_used;
  logic [KEY_BITS-1:0]  slot_key   [TABLE_DEPTH];
  logic [47:0]          slot_calls [TABLE_DEPTH];
  logic [TIME_BITS-1:0] slot_ticks [TABLE_DEPTH];

  rsp_t expected_reads [$];
  int   mismatches = 0;
  logic drained = 1'b0;

  // Print one line per mismatch and count it
  task automatic report(input string what);
    mismatches++;
    $display("%0t ns  stats table mismatch: %s", $time, what);
  endtask

  // Add and clamp to all ones on carry out
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[48] ? {48{1'b1}} : sum[47:0];
  endfunction

  // Find or insert the latched key, then add one call and the elapsed ticks
  task automatic record_exit(input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] elapsed;
    int hit;
    elapsed = now - latched_stamp;
    hit = -1;
    for (int i = 0; i < slots_used; i++)
      if (hit < 0 && slot_key[i] == latched_key) hit = i;
    // Drop the call when the key is new and no slot is free
    if (hit < 0 && slots_used < TABLE_DEPTH) begin
      hit = slots_used;
      slot_key[hit] = latched_key;
      slot_calls[hit] = '0;
      slot_ticks[hit] = '0;
      slots_used++;
    end
    if (hit >= 0) begin
      slot_calls[hit] = sat_add48(slot_calls[hit], 48'd1);
      slot_ticks[hit] = sat_add48(slot_ticks[hit], elapsed);
    end
  endtask

  // Contents of one slot and its rank by calls descending, then slot ascending
  function automatic rsp_t predict_read(input logic [9:0] slot);
    rsp_t r;
    int s;
    r = '0;
    s = slot;
    if (s < slots_used) begin
      r.valid_res = 1'b1;
      r.entry_key = slot_key[s];
      r.entry_calls = slot_calls[s];
      r.total_ticks = slot_ticks[s];
      for (int j = 0; j < slots_used; j++)
        if (slot_calls[j] > slot_calls[s] || (slot_calls[j] == slot_calls[s] && j < s))
          r.entry_rank = r.entry_rank + 10'd1;
    end
    r.entries_used = 11'(slots_used);
    return r;
  endfunction

  // Advance the predicted state by one accepted request
  task automatic apply_request(input req_t r);
    case (r.operation)
      OP_STOP: begin
        if (awaiting_entry) begin
          latched_key = r.call_num;
          latched_stamp = r.timestamp;
          awaiting_entry = 1'b0;
        end else begin
          record_exit(r.timestamp);
          awaiting_entry = 1'b1;
        end
      end
      OP_READ:  expected_reads.push_back(predict_read(r.slot));
      OP_CLEAR: slots_used = 0;
      default: ;
    endcase
  endtask

  // Compare one result with the oldest prediction, field by field
  task automatic check_read(input rsp_t got);
    rsp_t want;
    if (expected_reads.size() == 0) begin
      report($sformatf("result with no read waiting, key %0d", got.entry_key));
      return;
    end
    want = expected_reads.pop_front();
    if (got.valid_res !== want.valid_res)
      report($sformatf("valid_res got %0d want %0d", got.valid_res, want.valid_res));
    if (got.entry_key !== want.entry_key)
      report($sformatf("entry_key got %0d want %0d", got.entry_key, want.entry_key));
    if (got.entry_calls !== want.entry_calls)
      report($sformatf("entry_calls got %0d want %0d", got.entry_calls, want.entry_calls));
    if (got.total_ticks !== want.total_ticks)
      report($sformatf("total_ticks got %0d want %0d", got.total_ticks, want.total_ticks));
    if (got.entry_rank !== want.entry_rank)
      report($sformatf("entry_rank got %0d want %0d", got.entry_rank, want.entry_rank));
    if (got.entries_used !== want.entries_used)
      report($sformatf("entries_used got %0d want %0d", got.entries_used, want.entries_used));
  endtask

  // Check results before taking new requests so the oldest prediction is matched
  always @(posedge clk) begin
    if (rst) begin
      awaiting_entry = 1'b1;
      latched_key = '0;
      latched_stamp = '0;
      slots_used = 0;
      expected_reads.delete();
    end else begin
      if (rsp_valid && rsp_ready) check_read(rsp);
      if (req_valid && req_ready) apply_request(req);
      if (drain_done && !drained) begin
        drained = 1'b1;
        if (expected_reads.size() != 0) begin
          report($sformatf("%0d read results never arrived", expected_reads.size()));
          expected_reads.delete();
        end
      end
    end
    errors <= mismatches;
    pending <= expected_reads.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top: drives requests and result backpressure, and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import sest_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 64;
  localparam int FILL_KEYS    = 40;
  localparam int MIX_ITEMS    = 280;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic drain_done = 1'b0;
  logic idle_on = 1'b1;
  logic pressure_go = 1'b0;
  logic pressure_done = 1'b0;
  int   hold_left = 0;
  int   errors;
  int   pending;
  logic [47:0] clock_now = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  syscall_event_stats_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  stats_table_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .drain_done (drain_done),
    .errors     (errors),
    .pending    (pending)
  );

  // Stall results at random; hold off once for a long stretch when asked
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !idle_on || ($urandom_range(99) >= 27);
    end
  end

  function automatic logic [47:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Advance the monotonic stop clock by a random step
  function automatic logic [47:0] next_stamp();
    clock_now = clock_now + 48'($urandom_range(5000, 1));
    return clock_now;
  endfunction

  // Offer one request, with random idle cycles first, and hold it until accepted
  task automatic send_req(input req_t item);
    while (idle_on && $urandom_range(99) < 27) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_stop(input logic [9:0] key, input logic [47:0] stamp);
    req_t item;
    item.operation = OP_STOP;
    item.call_num = key;
    item.timestamp = stamp;
    item.slot = 10'($urandom_range(1023));
    send_req(item);
  endtask

  task automatic send_read(input logic [9:0] slot);
    req_t item;
    item.operation = OP_READ;
    item.call_num = 10'($urandom_range(1023));
    item.timestamp = rand_stamp();
    item.slot = slot;
    send_req(item);
  endtask

  // Clear or unused code, other fields random
  task automatic send_plain(input logic [1:0] op);
    req_t item;
    item.operation = op;
    item.call_num = 10'($urandom_range(1023));
    item.timestamp = rand_stamp();
    item.slot = 10'($urandom_range(1023));
    send_req(item);
  endtask

  // Entry then exit; the exit carries an unrelated syscall number
  task automatic call_pair(input logic [9:0] key, input logic [47:0] start,
                           input logic [47:0] span);
    send_stop(key, start);
    send_stop(10'($urandom_range(1023)), start + span);
  endtask

  initial begin
    logic [9:0] key;
    int pick;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty table, unused code, and the extremes of elapsed time
    send_read(10'd0);
    send_plain(OP_UNUSED);
    call_pair(10'd0, 48'd0, TIME_MAX);
    call_pair(10'd0, 48'd5, TIME_MAX);
    call_pair(10'd1023, TIME_MAX - 48'd5, 48'd16);
    call_pair(10'd7, 48'd100, 48'd0);
    call_pair(10'd7, 48'd200, 48'd100);
    send_read(10'd0);
    send_read(10'd1);
    send_read(10'd2);
    send_read(10'd3);
    send_read(10'd1023);

    // Clear between entry and exit keeps the latched key and stamp
    send_stop(10'd9, 48'd1000);
    send_plain(OP_CLEAR);
    send_stop(10'd512, 48'd1500);
    send_read(10'd0);
    send_read(10'd1);

    // Fill a run of slots with distinct keys, then hit an existing key
    send_plain(OP_CLEAR);
    for (int k = 0; k < FILL_KEYS; k++) begin
      key = k[9:0] ^ 10'h155;
      call_pair(key, next_stamp(), 48'($urandom_range(9999)));
    end
    call_pair(10'h155, next_stamp(), 48'd77);
    send_read(10'd0);
    send_read(10'(FILL_KEYS - 1));
    send_read(10'(FILL_KEYS));
    repeat (3) send_read(10'($urandom_range(63)));

    // Back-to-back reads while the result side holds off, so the input stalls
    send_plain(OP_CLEAR);
    idle_on <= 1'b0;
    pressure_go <= 1'b1;
    repeat (12) send_read(10'($urandom_range(3)));

    // Random mix: mostly stops on a small key pool, reads near the fill level
    for (int n = 0; n < MIX_ITEMS; n++) begin
      if (n == 80) idle_on <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 55) begin
        key = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(31));
        send_stop(key, ($urandom_range(19) == 0) ? rand_stamp() : next_stamp());
      end else if (pick < 92) begin
        send_read(($urandom_range(7) == 0) ? 10'($urandom_range(1023))
                                            : 10'($urandom_range(40)));
      end else if (pick < 96) begin
        send_plain(OP_CLEAR);
      end else begin
        send_plain(OP_UNUSED);
      end
    end

    // Drain: wait for all predicted reads, then let the scan finish
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0) begin
      $display("syscall_event_stats_table_unit regression: pass");
    end else begin
      $display("syscall_event_stats_table_unit regression: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #80_000_000;
    $display("syscall_event_stats_table_unit regression: fail");
    $finish;
  end

endmodule
